// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is high.
`define CF_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("clock face check failed");

// Clocked check that also holds while reset is high.
`define CF_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("clock face check failed");

`endif

// ----- sv/cfcd_pkg.sv -----
`default_nettype none

package cfcd_pkg;

  typedef enum logic [1:0] {
    MODE_SECOND = 2'd0,
    MODE_SCAN   = 2'd1,
    MODE_SET    = 2'd2
  } mode_t;

  localparam int unsigned FACE_W     = 60;
  localparam int unsigned LINES      = 8;
  localparam int unsigned HOUR_PAIRS = 6;

  localparam logic [5:0] SEC_LAST  = 6'd59;
  localparam logic [5:0] MIN_LAST  = 6'd59;
  localparam logic [3:0] HOUR_LAST = 4'd11;

  // Face position of the ring LED between anode line (row) and cathode line (column).
  localparam logic [5:0] RING_POS [0:LINES-1][0:LINES-1] = '{
    '{6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd6,  6'd7,  6'd0},
    '{6'd8,  6'd0,  6'd9,  6'd11, 6'd12, 6'd13, 6'd14, 6'd0},
    '{6'd16, 6'd17, 6'd0,  6'd18, 6'd19, 6'd21, 6'd22, 6'd0},
    '{6'd23, 6'd24, 6'd26, 6'd0,  6'd27, 6'd28, 6'd29, 6'd0},
    '{6'd31, 6'd32, 6'd33, 6'd34, 6'd0,  6'd36, 6'd37, 6'd0},
    '{6'd38, 6'd39, 6'd41, 6'd42, 6'd43, 6'd0,  6'd44, 6'd0},
    '{6'd46, 6'd47, 6'd48, 6'd49, 6'd51, 6'd52, 6'd0,  6'd0},
    '{6'd53, 6'd54, 6'd56, 6'd57, 6'd58, 6'd59, 6'd0,  6'd0}
  };

  // Bit c set where an LED sits between the anode row and cathode line c.
  localparam logic [LINES-1:0] RING_HAS [0:LINES-1] = '{
    8'b0111_1110, 8'b0111_1101, 8'b0111_1011, 8'b0111_0111,
    8'b0110_1111, 8'b0101_1111, 8'b0011_1111, 8'b0011_1111
  };

endpackage

`default_nettype wire

// ----- sv/clock_face_charlieplex_driver_unit.sv -----
// Channel | Handshake           | Beat contents
// --------+---------------------+---------------------------------------------
// in      | in_valid / in_stall | mode, set_hours, set_minutes, set_seconds
// out     | out_valid/out_stall | line drive, hour lines, hour LEDs, time
//
// One beat in, one out in the next cycle; a beat enters any unstalled cycle.
// The time, face map and drive registers double as the result register, so
// in_stall is high only while a result waits under out_stall (or in reset).
// Reset clears the time, face map, scan counters and all drives.
`default_nettype none

module clock_face_charlieplex_driver_unit
  import cfcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] mode,
  input  wire logic [3:0] set_hours,
  input  wire logic [5:0] set_minutes,
  input  wire logic [5:0] set_seconds,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      line_drive_enable,
  output logic [7:0]      line_drive_level,
  output logic            hour_line_a,
  output logic            hour_line_b,
  output logic [5:0]      hour_led_lit,
  output logic [3:0]      cur_hours,
  output logic [5:0]      cur_minutes,
  output logic [5:0]      cur_seconds
);

  logic [FACE_W-1:0] face_map;
  logic [1:0]        hour_phase;
  logic [2:0]        scan_line;

  logic [FACE_W-1:0] face_map_next;
  logic [1:0]        hour_phase_next;
  logic [2:0]        scan_line_next;
  logic [7:0]        line_drive_enable_next;
  logic [7:0]        line_drive_level_next;
  logic              hour_line_a_next;
  logic              hour_line_b_next;
  logic [5:0]        hour_led_lit_next;
  logic [3:0]        cur_hours_next;
  logic [5:0]        cur_minutes_next;
  logic [5:0]        cur_seconds_next;

  logic [3:0]        tick_hours;
  logic [5:0]        tick_minutes;
  logic [5:0]        tick_seconds;
  logic [5:0]        tick_hour_pos;
  logic [HOUR_PAIRS-1:0] marks_even;
  logic [HOUR_PAIRS-1:0] marks_odd;
  logic [7:0]        cathodes;
  logic              accept;

  assign in_stall = rst | (out_valid & out_stall);
  assign accept   = in_valid & ~in_stall;

  // Time after a second tick, with rollover.
  always_comb begin
    tick_hours   = cur_hours;
    tick_minutes = cur_minutes;
    tick_seconds = cur_seconds + 6'd1;
    if (cur_seconds >= SEC_LAST) begin
      tick_seconds = '0;
      tick_minutes = cur_minutes + 6'd1;
      if (cur_minutes >= MIN_LAST) begin
        tick_minutes = '0;
        tick_hours   = (cur_hours >= HOUR_LAST) ? 4'd0 : cur_hours + 4'd1;
      end
    end
  end

  assign tick_hour_pos = {tick_hours, 2'b00} + {2'b00, tick_hours};

  // Hour marks sit every five positions; even and odd pairs share the six lines.
  always_comb begin
    for (int k = 0; k < HOUR_PAIRS; k++) begin
      marks_even[k] = face_map[10 * k];
      marks_odd[k]  = face_map[10 * k + 5];
    end
  end

  assign scan_line_next = scan_line + 3'd1;

  always_comb begin
    for (int c = 0; c < LINES; c++) begin
      cathodes[c] = RING_HAS[scan_line_next][c] &
                    face_map[RING_POS[scan_line_next][c]];
    end
  end

  always_comb begin
    face_map_next          = face_map;
    hour_phase_next        = hour_phase;
    line_drive_enable_next = line_drive_enable;
    line_drive_level_next  = line_drive_level;
    hour_line_a_next       = hour_line_a;
    hour_line_b_next       = hour_line_b;
    hour_led_lit_next      = hour_led_lit;
    cur_hours_next         = cur_hours;
    cur_minutes_next       = cur_minutes;
    cur_seconds_next       = cur_seconds;
    unique case (mode)
      MODE_SECOND: begin
        cur_hours_next   = tick_hours;
        cur_minutes_next = tick_minutes;
        cur_seconds_next = tick_seconds;
        face_map_next    = (FACE_W'(1) << tick_hour_pos) |
                           (FACE_W'(1) << tick_minutes) |
                           (FACE_W'(1) << tick_seconds);
      end
      MODE_SCAN: begin
        hour_phase_next   = hour_phase + 2'd1;
        hour_led_lit_next = '0;
        unique case (hour_phase_next)
          2'd1: begin
            hour_line_b_next  = 1'b0;
            hour_line_a_next  = 1'b1;
            hour_led_lit_next = marks_even;
          end
          2'd2: hour_line_a_next = 1'b0;
          2'd3: begin
            hour_line_a_next  = 1'b0;
            hour_line_b_next  = 1'b1;
            hour_led_lit_next = marks_odd;
          end
          default: hour_line_b_next = 1'b0;
        endcase
        line_drive_level_next  = 8'd1 << scan_line_next;
        line_drive_enable_next = (8'd1 << scan_line_next) | cathodes;
      end
      MODE_SET: begin
        cur_hours_next   = (set_hours > HOUR_LAST) ? HOUR_LAST : set_hours;
        cur_minutes_next = (set_minutes > MIN_LAST) ? MIN_LAST : set_minutes;
        cur_seconds_next = (set_seconds > SEC_LAST) ? SEC_LAST : set_seconds;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid         <= 1'b0;
      face_map          <= '0;
      hour_phase        <= '0;
      scan_line         <= '0;
      line_drive_enable <= '0;
      line_drive_level  <= '0;
      hour_line_a       <= 1'b0;
      hour_line_b       <= 1'b0;
      hour_led_lit      <= '0;
      cur_hours         <= '0;
      cur_minutes       <= '0;
      cur_seconds       <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        out_valid         <= 1'b1;
        face_map          <= face_map_next;
        hour_phase        <= hour_phase_next;
        line_drive_enable <= line_drive_enable_next;
        line_drive_level  <= line_drive_level_next;
        hour_line_a       <= hour_line_a_next;
        hour_line_b       <= hour_line_b_next;
        hour_led_lit      <= hour_led_lit_next;
        cur_hours         <= cur_hours_next;
        cur_minutes       <= cur_minutes_next;
        cur_seconds       <= cur_seconds_next;
        if (mode == MODE_SCAN) begin
          scan_line <= scan_line_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/cfcd_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module cfcd_checker
  import cfcd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [1:0] mode,
  input wire logic [3:0] set_hours,
  input wire logic [5:0] set_minutes,
  input wire logic [5:0] set_seconds,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] line_drive_enable,
  input wire logic [7:0] line_drive_level,
  input wire logic [5:0] hour_led_lit,
  input wire logic [3:0] cur_hours,
  input wire logic [5:0] cur_minutes,
  input wire logic [5:0] cur_seconds
);

  logic        in_take;
  logic        set_ok;
  logic [15:0] set_time;
  logic [15:0] cur_time;
  logic [21:0] scan_drive;
  logic        time_ok;
  logic        anode_ok;

  assign in_take    = in_valid && !in_stall;
  assign set_ok     = in_take && (mode == MODE_SET) &&
                      (set_hours <= HOUR_LAST) && (set_minutes <= MIN_LAST) &&
                      (set_seconds <= SEC_LAST);
  assign set_time   = {set_hours, set_minutes, set_seconds};
  assign cur_time   = {cur_hours, cur_minutes, cur_seconds};
  assign scan_drive = {line_drive_enable, line_drive_level, hour_led_lit};
  assign time_ok    = (cur_hours <= HOUR_LAST) && (cur_minutes <= MIN_LAST) &&
                      (cur_seconds <= SEC_LAST);
  assign anode_ok   = $onehot0(line_drive_level) &&
                      ((line_drive_level & ~line_drive_enable) == 8'd0);

  // Outside reset, a waiting result is the only thing that holds back input.
  `CF_ASSERT(a_stall_source, clk, rst, in_stall == (out_valid && out_stall))

  // An in-range set time shows up verbatim in the next beat.
  `CF_ASSERT(a_set_loads, clk, rst, set_ok |=> (out_valid && cur_time == $past(set_time)))

  // A second tick leaves the ring and hour drives alone.
  `CF_ASSERT(a_second_keeps_scan, clk, rst, (in_take && mode == MODE_SECOND) |=> $stable(scan_drive))

  // Time stays in range; at most one anode, and only on a driven line.
  `CF_ASSERT(a_state_sane, clk, rst, time_ok && anode_ok)

  // Reset drops the output beat and clears the time, line drives and hour LEDs.
  `CF_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (!out_valid && cur_time == '0 && scan_drive == '0))

endmodule

bind clock_face_charlieplex_driver_unit cfcd_checker u_cfcd_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .mode              (mode),
  .set_hours         (set_hours),
  .set_minutes       (set_minutes),
  .set_seconds       (set_seconds),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .line_drive_enable (line_drive_enable),
  .line_drive_level  (line_drive_level),
  .hour_led_lit      (hour_led_lit),
  .cur_hours         (cur_hours),
  .cur_minutes       (cur_minutes),
  .cur_seconds       (cur_seconds)
);

`default_nettype wire

// ----- verif/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cfcd_pkg::*;

  // Mode code that the block leaves unused: nothing changes on it.
  localparam logic [1:0] MODE_NONE = 2'd3;

  typedef struct {
    logic [7:0] en;
    logic [7:0] lvl;
    logic       a;
    logic       b;
    logic [5:0] led;
    logic [3:0] hr;
    logic [5:0] mn;
    logic [5:0] sc;
  } face_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] mode = MODE_NONE;
  logic [3:0] set_hours = '0;
  logic [5:0] set_minutes = '0;
  logic [5:0] set_seconds = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] line_drive_enable;
  logic [7:0] line_drive_level;
  logic       hour_line_a;
  logic       hour_line_b;
  logic [5:0] hour_led_lit;
  logic [3:0] cur_hours;
  logic [5:0] cur_minutes;
  logic [5:0] cur_seconds;

  // Watch state as the block should hold it.
  int          w_sec = 0;
  int          w_min = 0;
  int          w_hour = 0;
  logic [59:0] w_face = '0;
  logic [1:0]  w_phase = '0;
  logic [2:0]  w_line = '0;
  logic [7:0]  w_en = '0;
  logic [7:0]  w_lvl = '0;
  logic        w_a = 1'b0;
  logic        w_b = 1'b0;
  logic [5:0]  w_led = '0;

  face_beat_t display_q[$];
  int         errors = 0;

  logic       tx_quiet = 1'b0;
  logic       rx_quiet = 1'b0;
  logic       rx_hold = 1'b0;
  int         rx_hold_len = 0;

  clock_face_charlieplex_driver_unit u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .mode             (mode),
    .set_hours        (set_hours),
    .set_minutes      (set_minutes),
    .set_seconds      (set_seconds),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .line_drive_enable(line_drive_enable),
    .line_drive_level (line_drive_level),
    .hour_line_a      (hour_line_a),
    .hour_line_b      (hour_line_b),
    .hour_led_lit     (hour_led_lit),
    .cur_hours        (cur_hours),
    .cur_minutes      (cur_minutes),
    .cur_seconds      (cur_seconds)
  );

  always #5 clk = ~clk;

  // Ring LEDs fill the non-hour positions 1..59 in anode-major order, six per anode,
  // skipping the diagonal and line 7 as cathode. Returns -1 where no LED sits.
  function automatic int ring_cell(input int anode, input int cathode);
    int n;
    if (cathode == 7 || cathode == anode) return -1;
    n = anode * 6 + ((cathode < anode) ? cathode : cathode - 1);
    if (n >= 48) return -1;
    return n + n / 4 + 1;
  endfunction

  task automatic advance_watch(input logic [1:0] md, input logic [3:0] h,
                               input logic [5:0] m, input logic [5:0] s);
    face_beat_t res;
    int         base;
    int         pos;
    logic       show;
    base = 0;
    show = 1'b0;
    case (md)
      MODE_SECOND: begin
        w_sec++;
        if (w_sec > 59) begin
          w_sec = 0;
          w_min++;
        end
        if (w_min > 59) begin
          w_min = 0;
          w_hour++;
        end
        if (w_hour > 11) w_hour = 0;
        w_face = '0;
        w_face[w_hour * 5] = 1'b1;
        w_face[w_min] = 1'b1;
        w_face[w_sec] = 1'b1;
      end
      MODE_SCAN: begin
        w_led = '0;
        w_phase = w_phase + 2'd1;
        case (w_phase)
          2'd1: begin
            w_b = 1'b0;
            w_a = 1'b1;
            show = 1'b1;
            base = 0;
          end
          2'd2: w_a = 1'b0;
          2'd3: begin
            w_a = 1'b0;
            w_b = 1'b1;
            show = 1'b1;
            base = 5;
          end
          default: w_b = 1'b0;
        endcase
        if (show)
          for (int k = 0; k < 6; k++)
            if (w_face[10 * k + base]) w_led[k] = 1'b1;
        w_line = w_line + 3'd1;
        w_en = 8'd1 << w_line;
        w_lvl = 8'd1 << w_line;
        for (int c = 0; c < 8; c++) begin
          pos = ring_cell(int'(w_line), c);
          if (pos >= 0 && w_face[pos]) w_en[c] = 1'b1;
        end
      end
      MODE_SET: begin
        // Saturate out-of-range values; the face map waits for the next second.
        w_hour = (h > 4'd11) ? 11 : int'(h);
        w_min = (m > 6'd59) ? 59 : int'(m);
        w_sec = (s > 6'd59) ? 59 : int'(s);
      end
      default: ;
    endcase
    res.en = w_en;
    res.lvl = w_lvl;
    res.a = w_a;
    res.b = w_b;
    res.led = w_led;
    res.hr = w_hour[3:0];
    res.mn = w_min[5:0];
    res.sc = w_sec[5:0];
    display_q.push_back(res);
  endtask

  task automatic report_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  // Check the result beat, then predict the input beat taken at this edge.
  always @(posedge clk) begin
    face_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (display_q.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        errors++;
      end else begin
        want = display_q.pop_front();
        report_field("line_drive_enable", int'(want.en), int'(line_drive_enable));
        report_field("line_drive_level", int'(want.lvl), int'(line_drive_level));
        report_field("hour_line_a", int'(want.a), int'(hour_line_a));
        report_field("hour_line_b", int'(want.b), int'(hour_line_b));
        report_field("hour_led_lit", int'(want.led), int'(hour_led_lit));
        report_field("cur_hours", int'(want.hr), int'(cur_hours));
        report_field("cur_minutes", int'(want.mn), int'(cur_minutes));
        report_field("cur_seconds", int'(want.sc), int'(cur_seconds));
      end
    end
    if (!rst && in_valid && !in_stall)
      advance_watch(mode, set_hours, set_minutes, set_seconds);
  end

  always @(posedge clk)
    out_stall <= rx_hold || (!rx_quiet && $urandom_range(99) < 6);

  // Hold the receiver off for the requested hold length.
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_len > 0) begin
        rx_hold <= 1'b1;
        repeat (rx_hold_len) @(posedge clk);
        rx_hold <= 1'b0;
        rx_hold_len = 0;
      end
    end
  end

  task automatic send_beat(input logic [1:0] md, input logic [3:0] h,
                           input logic [5:0] m, input logic [5:0] s);
    if (!tx_quiet)
      while ($urandom_range(99) < 6) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid <= 1'b1;
    mode <= md;
    set_hours <= h;
    set_minutes <= m;
    set_seconds <= s;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_tick(input logic [1:0] md);
    send_beat(md, 4'($urandom_range(15)), 6'($urandom_range(63)),
              6'($urandom_range(63)));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (display_q.size() != 0);
  endtask

  task automatic test_reset_state;
    send_tick(MODE_NONE);
    send_tick(MODE_SCAN);
    send_tick(MODE_SECOND);
    drain();
  endtask

  task automatic test_rollover;
    send_beat(MODE_SET, 4'd10, 6'd59, 6'd59);
    send_tick(MODE_SECOND);
    send_beat(MODE_SET, 4'd11, 6'd59, 6'd59);
    send_tick(MODE_SECOND);
    send_beat(MODE_SET, 4'd2, 6'd30, 6'd59);
    send_tick(MODE_SECOND);
    drain();
  endtask

  task automatic test_saturation;
    send_beat(MODE_SET, 4'd15, 6'd63, 6'd63);
    send_beat(MODE_SET, 4'd12, 6'd60, 6'd60);
    send_beat(MODE_SET, 4'd0, 6'd0, 6'd0);
    send_tick(MODE_NONE);
    drain();
  endtask

  task automatic test_scan_walk;
    // Set time without a second tick: the old face map keeps driving the scan.
    send_beat(MODE_SET, 4'd3, 6'd17, 6'd42);
    send_tick(MODE_SCAN);
    send_tick(MODE_SECOND);
    repeat (8) send_tick(MODE_SCAN);
    send_tick(MODE_NONE);
    drain();
  endtask

  task automatic test_backpressure;
    rx_hold_len = 40;
    repeat (16) send_tick(($urandom_range(1) == 0) ? MODE_SECOND : MODE_SCAN);
    drain();
  endtask

  task automatic test_random(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      // Run a long stretch with neither side idling.
      if (i == count / 3) begin
        tx_quiet = 1'b1;
        rx_quiet <= 1'b1;
      end
      if (i == count / 3 + 100) begin
        tx_quiet = 1'b0;
        rx_quiet <= 1'b0;
      end
      r = $urandom_range(99);
      if (r < 40) send_tick(MODE_SECOND);
      else if (r < 80) send_tick(MODE_SCAN);
      else if (r < 95)
        send_beat(MODE_SET,
                  4'(($urandom_range(99) < 20) ? $urandom_range(15) : $urandom_range(11)),
                  6'(($urandom_range(99) < 20) ? $urandom_range(63) : $urandom_range(59)),
                  6'(($urandom_range(99) < 20) ? $urandom_range(63) : $urandom_range(59)));
      else send_tick(MODE_NONE);
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_rollover();
    test_saturation();
    test_scan_walk();
    test_backpressure();
    test_random(360);
    repeat (5) @(posedge clk);
    if (display_q.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, display_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- clock_face_charlieplex_driver_unit.f -----
+incdir+sv
sv/cfcd_pkg.sv
sv/clock_face_charlieplex_driver_unit.sv
sv/cfcd_checker.sv
verif/testbench.sv
